// ===== design/rtc_calendar_from_tick_counter_unit_defines.svh =====
// Assertion helpers for the real-time clock calendar.
// Each helper expects a clock named aclk and an active-low reset named aresetn.
`ifndef RTC_CALENDAR_FROM_TICK_COUNTER_UNIT_DEFINES_SVH
`define RTC_CALENDAR_FROM_TICK_COUNTER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rtc calendar check failed");

// The consequent must hold in the cycle after the antecedent.
`define RTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rtc calendar check failed");

`endif

// ===== design/rtc_pkg.sv =====
`default_nettype none

package rtc_pkg;

    // Counter and time field widths.
    localparam int unsigned COUNT_W = 24;
    localparam int unsigned FRAC_W  = 15;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned WDAY_W  = 3;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned FIELD_W = 8;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_SYNC     = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_TIME = 2'd1;
    localparam logic [OP_W-1:0] OP_SET_DATE = 2'd2;

    // Default calendar parameters.
    localparam int unsigned DEF_MIN_YEAR   = 2000;
    localparam int unsigned DEF_MAX_YEAR   = 2099;
    localparam int unsigned DEF_INIT_YEAR  = 2010;
    localparam int unsigned DEF_INIT_MONTH = 1;
    localparam int unsigned DEF_INIT_DAY   = 1;

    // Time of day after reset.
    localparam logic [HOUR_W-1:0] HOUR_RESET = 5'd9;

    // Largest number of minutes one sync can carry out of the seconds field.
    localparam int unsigned SEC_CARRY_MAX = (59 + (1 << (COUNT_W - FRAC_W))) / 60;

    // Divisibility by 25 through the multiplicative inverse modulo 2^k.
    localparam int unsigned INV25       = 41;
    localparam int unsigned DIV25_LIM10 = ((1 << 10) - 1) / 25;
    localparam int unsigned DIV25_LIM8  = ((1 << 8) - 1) / 25;

    // Reciprocal of 25 scaled by 2^16, rounded up, for floor division.
    localparam int unsigned RECIP25_SH = 16;
    localparam int unsigned RECIP25    = (1 << RECIP25_SH) / 25 + 1;

    // Offset that keeps the year positive in the weekday sum.
    localparam int unsigned YEAR_SHIFT = 400;

    // Month lengths; codes that are not months read as 31.
    localparam logic [DAY_W-1:0] MONTH_DAYS [16] = '{
        5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
    };

    // Control handed from the input stage to the state units.
    typedef struct packed {
        logic            step;
        logic [OP_W-1:0] op;
    } ctl_t;

    // Status handed from the time unit to the date unit and the top level.
    typedef struct packed {
        logic time_ok;
        logic day_carry;
    } time_sts_t;

    // Gregorian leap year test.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [19:0] prod100;
        logic [15:0] prod400;
        logic        div4;
        logic        div100;
        logic        div400;
        div4    = (y[1:0] == 2'd0);
        prod100 = {10'd0, y[11:2]} * 20'(INV25);
        prod400 = {8'd0, y[11:4]} * 16'(INV25);
        div100  = div4 && (prod100[9:0] <= 10'(DIV25_LIM10));
        div400  = (y[3:0] == 4'd0) && (prod400[7:0] <= 8'(DIV25_LIM8));
        return div400 || (div4 && !div100);
    endfunction

    // Days in month m of year y.
    function automatic logic [DAY_W-1:0] month_len(input logic [YEAR_W-1:0] y,
                                                   input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        if ((m == 4'd2) && is_leap(y)) begin
            len = 5'd29;
        end else begin
            len = MONTH_DAYS[m];
        end
        return len;
    endfunction

    // Day of the week, 0 Monday to 6 Sunday, proleptic Gregorian.
    function automatic logic [WDAY_W-1:0] weekday_of(input logic [YEAR_W-1:0]  y,
                                                     input logic [MONTH_W-1:0] m,
                                                     input logic [DAY_W-1:0]   d);
        logic        early;
        logic [13:0] yy;
        logic [4:0]  mm;
        logic [6:0]  m3;
        logic [10:0] m3_prod;
        logic [27:0] prod100;
        logic [27:0] prod400;
        logic [13:0] q100;
        logic [13:0] q400;
        logic [13:0] sum;
        logic [4:0]  fold1;
        logic [3:0]  fold2;
        early   = (m <= 4'd2);
        yy      = 14'(y) + 14'(YEAR_SHIFT) - 14'(early);
        mm      = early ? (5'(m) + 5'd12) : 5'(m);
        m3      = (7'(mm) + 7'd1) * 7'd3;
        // Three fifths term: x * 13 / 64 is exact for x up to 48.
        m3_prod = 11'(m3) * 11'd13;
        prod100 = 28'(yy[13:2]) * 28'(RECIP25);
        prod400 = 28'(yy[13:4]) * 28'(RECIP25);
        q100    = 14'(prod100 >> RECIP25_SH);
        q400    = 14'(prod400 >> RECIP25_SH);
        sum     = 14'(d) + 14'({mm, 1'b0}) + 14'(m3_prod[10:6]) + yy + 14'(yy[13:2])
                  - q100 + q400;
        // Modulo 7 by folding octal digits, since 8 is one more than 7.
        fold1   = 5'(sum[2:0]) + 5'(sum[5:3]) + 5'(sum[8:6]) + 5'(sum[11:9])
                  + 5'(sum[13:12]);
        fold2   = 4'(fold1[4:3]) + 4'(fold1[2:0]);
        return (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/rtc_time_unit.sv =====
`default_nettype none

module rtc_time_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rtc_pkg::ctl_t                 ctl,
    input  wire logic [rtc_pkg::COUNT_W-1:0]   timer_count,
    input  wire logic [rtc_pkg::FIELD_W-1:0]   hour_in,
    input  wire logic [rtc_pkg::FIELD_W-1:0]   minute_in,
    input  wire logic [rtc_pkg::FIELD_W-1:0]   second_in,
    output rtc_pkg::time_sts_t                 sts,
    output logic [rtc_pkg::HOUR_W-1:0]         hour,
    output logic [rtc_pkg::MIN_W-1:0]          minute,
    output logic [rtc_pkg::SEC_W-1:0]          second
);

    import rtc_pkg::*;

    logic [COUNT_W-1:0] ref_reg,  ref_next;
    logic [FRAC_W-1:0]  frac_reg, frac_next;
    logic [HOUR_W-1:0]  hour_reg, hour_next;
    logic [MIN_W-1:0]   min_reg,  min_next;
    logic [SEC_W-1:0]   sec_reg,  sec_next;

    logic [COUNT_W-1:0] delta;
    logic [FRAC_W:0]    frac_sum;
    logic [9:0]         sec_tot;
    logic [3:0]         min_carry;
    logic [9:0]         sec_base;
    logic [SEC_W-1:0]   sec_sync;
    logic [6:0]         min_tot;
    logic [MIN_W-1:0]   min_sync;
    logic               hour_carry;
    logic [HOUR_W-1:0]  hour_tot;
    logic [HOUR_W-1:0]  hour_sync;
    logic               midnight;
    logic               time_ok;

    // Elapsed ticks with wrap, split into whole seconds and the carried fraction.
    assign delta    = timer_count - ref_reg;
    assign frac_sum = {1'b0, frac_reg} + {1'b0, delta[FRAC_W-1:0]};
    assign sec_tot  = 10'(delta[COUNT_W-1:FRAC_W]) + 10'(frac_sum[FRAC_W])
                      + 10'(sec_reg);

    // Minutes carried out of the seconds field, found by parallel compares.
    always_comb begin
        min_carry = '0;
        sec_base  = '0;
        for (int k = 1; k <= SEC_CARRY_MAX; k++) begin
            if (sec_tot >= 10'(k * 60)) begin
                min_carry = 4'(k);
                sec_base  = 10'(k * 60);
            end
        end
    end

    assign sec_sync = SEC_W'(sec_tot - sec_base);

    // Minute and hour carries each move at most one step.
    always_comb begin
        min_tot = 7'(min_reg) + 7'(min_carry);
        if (min_tot >= 7'd60) begin
            min_sync   = MIN_W'(min_tot - 7'd60);
            hour_carry = 1'b1;
        end else begin
            min_sync   = min_tot[MIN_W-1:0];
            hour_carry = 1'b0;
        end
        hour_tot = hour_reg + HOUR_W'(hour_carry);
        if (hour_tot >= 5'd24) begin
            hour_sync = '0;
            midnight  = 1'b1;
        end else begin
            hour_sync = hour_tot;
            midnight  = 1'b0;
        end
    end

    assign time_ok = (hour_in <= 8'd23) && (minute_in <= 8'd59) && (second_in <= 8'd59);

    // Next state for the operation in the input stage.
    always_comb begin
        ref_next  = ref_reg;
        frac_next = frac_reg;
        hour_next = hour_reg;
        min_next  = min_reg;
        sec_next  = sec_reg;
        if (ctl.step) begin
            case (ctl.op)
                OP_SYNC: begin
                    ref_next  = timer_count;
                    frac_next = frac_sum[FRAC_W-1:0];
                    hour_next = hour_sync;
                    min_next  = min_sync;
                    sec_next  = sec_sync;
                end
                OP_SET_TIME: begin
                    if (time_ok) begin
                        ref_next  = timer_count;
                        hour_next = HOUR_W'(hour_in);
                        min_next  = MIN_W'(minute_in);
                        sec_next  = SEC_W'(second_in);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg  <= '0;
            frac_reg <= '0;
            hour_reg <= HOUR_RESET;
            min_reg  <= '0;
            sec_reg  <= '0;
        end else begin
            ref_reg  <= ref_next;
            frac_reg <= frac_next;
            hour_reg <= hour_next;
            min_reg  <= min_next;
            sec_reg  <= sec_next;
        end
    end

    assign sts.time_ok   = time_ok;
    assign sts.day_carry = midnight;
    assign hour          = hour_reg;
    assign minute        = min_reg;
    assign second        = sec_reg;

endmodule

`default_nettype wire

// ===== design/rtc_date_unit.sv =====
`default_nettype none

module rtc_date_unit #(
    parameter int unsigned MIN_YEAR   = rtc_pkg::DEF_MIN_YEAR,
    parameter int unsigned MAX_YEAR   = rtc_pkg::DEF_MAX_YEAR,
    parameter int unsigned INIT_YEAR  = rtc_pkg::DEF_INIT_YEAR,
    parameter int unsigned INIT_MONTH = rtc_pkg::DEF_INIT_MONTH,
    parameter int unsigned INIT_DAY   = rtc_pkg::DEF_INIT_DAY
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rtc_pkg::ctl_t                 ctl,
    input  wire rtc_pkg::time_sts_t            time_sts,
    input  wire logic [rtc_pkg::YEAR_W-1:0]    year_in,
    input  wire logic [rtc_pkg::MONTH_W-1:0]   month_in,
    input  wire logic [rtc_pkg::DAY_W-1:0]     day_in,
    output logic                               date_ok,
    output logic [rtc_pkg::YEAR_W-1:0]         year,
    output logic [rtc_pkg::MONTH_W-1:0]        month,
    output logic [rtc_pkg::DAY_W-1:0]          day,
    output logic [rtc_pkg::WDAY_W-1:0]         weekday
);

    import rtc_pkg::*;

    // Weekday after reset, and of the first day of year 0 for the year wrap.
    localparam logic [WDAY_W-1:0] WDAY_RESET =
        weekday_of(YEAR_W'(INIT_YEAR), MONTH_W'(INIT_MONTH), DAY_W'(INIT_DAY));
    localparam logic [WDAY_W-1:0] WDAY_YEAR0 = weekday_of('0, 4'd1, 5'd1);

    logic [YEAR_W-1:0]  year_reg,  year_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [DAY_W-1:0]   day_reg,   day_next;
    logic [WDAY_W-1:0]  wday_reg,  wday_next;

    logic [DAY_W-1:0]   cur_len;
    logic [DAY_W-1:0]   in_len;
    logic [YEAR_W-1:0]  adv_year;
    logic [MONTH_W-1:0] adv_month;
    logic [DAY_W-1:0]   adv_day;
    logic [WDAY_W-1:0]  adv_wday;
    logic [WDAY_W-1:0]  in_wday;

    // Advance the stored date by one day past midnight.
    always_comb begin
        cur_len   = month_len(year_reg, month_reg);
        adv_year  = year_reg;
        adv_month = month_reg;
        adv_day   = day_reg + 5'd1;
        adv_wday  = (wday_reg >= 3'd6) ? '0 : wday_reg + 3'd1;
        if (day_reg >= cur_len) begin
            adv_day   = 5'd1;
            adv_month = month_reg + 4'd1;
            if (month_reg >= 4'd12) begin
                adv_month = 4'd1;
                adv_year  = year_reg + 12'd1;
                // The year counter wraps to 0, where the weekday does not follow on.
                if (year_reg == '1) begin
                    adv_wday = WDAY_YEAR0;
                end
            end
        end
    end

    // Check and look up a date being set.
    assign in_len  = month_len(year_in, month_in);
    assign date_ok = (year_in >= YEAR_W'(MIN_YEAR)) && (year_in <= YEAR_W'(MAX_YEAR))
                     && (month_in >= 4'd1) && (month_in <= 4'd12)
                     && (day_in >= 5'd1) && (day_in <= in_len);
    assign in_wday = weekday_of(year_in, month_in, day_in);

    always_comb begin
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        wday_next  = wday_reg;
        if (ctl.step) begin
            case (ctl.op)
                OP_SYNC: begin
                    if (time_sts.day_carry) begin
                        year_next  = adv_year;
                        month_next = adv_month;
                        day_next   = adv_day;
                        wday_next  = adv_wday;
                    end
                end
                OP_SET_DATE: begin
                    if (date_ok) begin
                        year_next  = year_in;
                        month_next = month_in;
                        day_next   = day_in;
                        wday_next  = in_wday;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            year_reg  <= YEAR_W'(INIT_YEAR);
            month_reg <= MONTH_W'(INIT_MONTH);
            day_reg   <= DAY_W'(INIT_DAY);
            wday_reg  <= WDAY_RESET;
        end else begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
            wday_reg  <= wday_next;
        end
    end

    assign year    = year_reg;
    assign month   = month_reg;
    assign day     = day_reg;
    assign weekday = wday_reg;

endmodule

`default_nettype wire

// ===== design/rtc_calendar_from_tick_counter_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   op, timer_count, time and date to set
// m_        out        m_valid / m_ready   accepted, time, date, weekday
//
// One item is taken per cycle unless the result side stalls; each item is held in the input register,
// then applied by the calendar state update, whose registers hold the offered result.
// Reset is synchronous; the block takes items from the first cycle after reset.
// A stalled result holds the state; the input register still takes one more item if it is empty.

`include "rtc_calendar_from_tick_counter_unit_defines.svh"

module rtc_calendar_from_tick_counter_unit #(
    parameter int unsigned MIN_YEAR   = rtc_pkg::DEF_MIN_YEAR,
    parameter int unsigned MAX_YEAR   = rtc_pkg::DEF_MAX_YEAR,
    parameter int unsigned INIT_YEAR  = rtc_pkg::DEF_INIT_YEAR,
    parameter int unsigned INIT_MONTH = rtc_pkg::DEF_INIT_MONTH,
    parameter int unsigned INIT_DAY   = rtc_pkg::DEF_INIT_DAY
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [rtc_pkg::OP_W-1:0]      s_op,
    input  wire logic [rtc_pkg::COUNT_W-1:0]   s_timer_count,
    input  wire logic [rtc_pkg::FIELD_W-1:0]   s_hour_in,
    input  wire logic [rtc_pkg::FIELD_W-1:0]   s_minute_in,
    input  wire logic [rtc_pkg::FIELD_W-1:0]   s_second_in,
    input  wire logic [rtc_pkg::YEAR_W-1:0]    s_year_in,
    input  wire logic [rtc_pkg::MONTH_W-1:0]   s_month_in,
    input  wire logic [rtc_pkg::DAY_W-1:0]     s_day_in,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_accepted,
    output logic [rtc_pkg::HOUR_W-1:0]         m_hour,
    output logic [rtc_pkg::MIN_W-1:0]          m_minute,
    output logic [rtc_pkg::SEC_W-1:0]          m_second,
    output logic [rtc_pkg::YEAR_W-1:0]         m_year,
    output logic [rtc_pkg::MONTH_W-1:0]        m_month,
    output logic [rtc_pkg::DAY_W-1:0]          m_day,
    output logic [rtc_pkg::WDAY_W-1:0]         m_weekday
);

    import rtc_pkg::*;

    // Input register.
    logic                in_vld_reg;
    logic [OP_W-1:0]     op_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [FIELD_W-1:0]  hour_in_reg;
    logic [FIELD_W-1:0]  minute_in_reg;
    logic [FIELD_W-1:0]  second_in_reg;
    logic [YEAR_W-1:0]   year_in_reg;
    logic [MONTH_W-1:0]  month_in_reg;
    logic [DAY_W-1:0]    day_in_reg;

    // Result control.
    logic                out_vld_reg, out_vld_next;
    logic                acc_reg,     acc_next;

    logic                advance;
    logic                step;
    ctl_t                ctl;
    time_sts_t           time_sts;
    logic                date_ok;

    // Range checks on the reported result.
    logic                time_in_range;
    logic                date_in_range;

    // The state registers double as the result register, so the result
    // stage moves whenever it is empty or being taken.
    assign advance = !out_vld_reg || m_ready;
    assign step    = in_vld_reg && advance;
    assign s_ready = !in_vld_reg || advance;

    assign ctl.step = step;
    assign ctl.op   = op_reg;

    // Capture an item when the input register is free or emptying.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg        <= s_op;
            count_reg     <= s_timer_count;
            hour_in_reg   <= s_hour_in;
            minute_in_reg <= s_minute_in;
            second_in_reg <= s_second_in;
            year_in_reg   <= s_year_in;
            month_in_reg  <= s_month_in;
            day_in_reg    <= s_day_in;
        end
    end

    rtc_time_unit u_time (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .timer_count (count_reg),
        .hour_in     (hour_in_reg),
        .minute_in   (minute_in_reg),
        .second_in   (second_in_reg),
        .sts         (time_sts),
        .hour        (m_hour),
        .minute      (m_minute),
        .second      (m_second)
    );

    rtc_date_unit #(
        .MIN_YEAR   (MIN_YEAR),
        .MAX_YEAR   (MAX_YEAR),
        .INIT_YEAR  (INIT_YEAR),
        .INIT_MONTH (INIT_MONTH),
        .INIT_DAY   (INIT_DAY)
    ) u_date (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .time_sts (time_sts),
        .year_in  (year_in_reg),
        .month_in (month_in_reg),
        .day_in   (day_in_reg),
        .date_ok  (date_ok),
        .year     (m_year),
        .month    (m_month),
        .day      (m_day),
        .weekday  (m_weekday)
    );

    // Acceptance flag and result valid.
    always_comb begin
        acc_next     = acc_reg;
        out_vld_next = out_vld_reg;
        if (step) begin
            out_vld_next = 1'b1;
            case (op_reg)
                OP_SYNC:     acc_next = 1'b1;
                OP_SET_TIME: acc_next = time_sts.time_ok;
                OP_SET_DATE: acc_next = date_ok;
                default:     acc_next = 1'b0;
            endcase
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
            acc_reg     <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
            acc_reg     <= acc_next;
        end
    end

    assign m_valid    = out_vld_reg;
    assign m_accepted = acc_reg;

    // The reported time must be a time of day; the month and weekday in range, the day not zero.
    assign time_in_range = (m_hour <= 5'd23) && (m_minute <= 6'd59) && (m_second <= 6'd59);
    assign date_in_range = (m_month >= 4'd1) && (m_month <= 4'd12) && (m_day >= 5'd1)
                           && (m_weekday <= 3'd6);

    // A held item stays in the input register while the result side stalls.
    `RTC_ASSERT_NEXT(a_input_held, in_vld_reg && !advance, in_vld_reg)
    // Every item that moves on produces a result in the next cycle.
    `RTC_ASSERT_NEXT(a_step_gives_result, step, out_vld_reg)
    // The reported time is a time of day whenever a result is offered.
    `RTC_ASSERT_NOW(a_time_range, out_vld_reg, time_in_range)
    // The reported month and weekday are in range, and the day is not zero.
    `RTC_ASSERT_NOW(a_date_range, out_vld_reg, date_in_range)

endmodule

`default_nettype wire

// ===== dv/rtc_calendar_from_tick_counter_unit_test.sv =====
`timescale 1ns / 1ps

module rtc_calendar_from_tick_counter_unit_test;

    import rtc_pkg::*;

    // Operation code that the block does not define.
    localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

    localparam int unsigned RESET_CYCLES = 6;
    localparam int unsigned NUM_DIRECTED = 25;
    localparam int unsigned NUM_RANDOM   = 1725;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned TICKS_PER_S  = 32768;

    // One input item, one field per port.
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COUNT_W-1:0] count;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] minute;
        logic [FIELD_W-1:0] second;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } rtc_command_t;

    // One result item as it leaves the block.
    typedef struct packed {
        logic               accepted;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [WDAY_W-1:0]  weekday;
    } rtc_reading_t;

    // A row of the directed table; pinned rows carry a result typed in by hand.
    typedef struct {
        rtc_command_t cmd;
        bit           pinned;
        rtc_reading_t want;
    } directed_row_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [OP_W-1:0]      s_op          = '0;
    logic [COUNT_W-1:0]   s_timer_count = '0;
    logic [FIELD_W-1:0]   s_hour_in     = '0;
    logic [FIELD_W-1:0]   s_minute_in   = '0;
    logic [FIELD_W-1:0]   s_second_in   = '0;
    logic [YEAR_W-1:0]    s_year_in     = '0;
    logic [MONTH_W-1:0]   s_month_in    = '0;
    logic [DAY_W-1:0]     s_day_in      = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic                 m_accepted;
    logic [HOUR_W-1:0]    m_hour;
    logic [MIN_W-1:0]     m_minute;
    logic [SEC_W-1:0]     m_second;
    logic [YEAR_W-1:0]    m_year;
    logic [MONTH_W-1:0]   m_month;
    logic [DAY_W-1:0]     m_day;
    logic [WDAY_W-1:0]    m_weekday;

    // Calendar state as the predictor sees it.
    logic [COUNT_W-1:0] cal_anchor = '0;
    int unsigned        cal_frac   = 0;
    int unsigned        cal_hour   = HOUR_RESET;
    int unsigned        cal_min    = 0;
    int unsigned        cal_sec    = 0;
    int unsigned        cal_year   = DEF_INIT_YEAR;
    int unsigned        cal_month  = DEF_INIT_MONTH;
    int unsigned        cal_day    = DEF_INIT_DAY;

    rtc_reading_t  expected_readings [$];
    directed_row_t directed_rows [NUM_DIRECTED];

    int unsigned fault_count  = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count  = 0;
    int unsigned gap_mode     = 1;
    bit          hold_request = 1'b0;

    rtc_calendar_from_tick_counter_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_timer_count (s_timer_count),
        .s_hour_in     (s_hour_in),
        .s_minute_in   (s_minute_in),
        .s_second_in   (s_second_in),
        .s_year_in     (s_year_in),
        .s_month_in    (s_month_in),
        .s_day_in      (s_day_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_accepted    (m_accepted),
        .m_hour        (m_hour),
        .m_minute      (m_minute),
        .m_second      (m_second),
        .m_year        (m_year),
        .m_month       (m_month),
        .m_day         (m_day),
        .m_weekday     (m_weekday)
    );

    // Free-running clock, 8 ns period.
    initial begin
        forever #4 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Gregorian leap year.
    function automatic bit leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    // Days in a month; codes that are not months count as 31.
    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        int unsigned len;
        case (m)
            4, 6, 9, 11: len = 30;
            2:           len = leap_year(y) ? 29 : 28;
            default:     len = 31;
        endcase
        return len;
    endfunction

    // Day of the week, Monday being 0; the year is shifted by 400 to stay positive.
    function automatic int unsigned day_of_week(input int unsigned y, input int unsigned m,
                                                input int unsigned d);
        y = y + 400;
        if (m <= 2) begin
            y = y - 1;
            m = m + 12;
        end
        return (d + 2 * m + 3 * (m + 1) / 5 + y + y / 4 - y / 100 + y / 400) % 7;
    endfunction

    // Applies one item to the calendar state and returns the reading it yields.
    function automatic rtc_reading_t advance_calendar(input rtc_command_t c);
        rtc_reading_t       r;
        logic [COUNT_W-1:0] elapsed;
        int unsigned        carry_secs;
        int unsigned        total;
        logic               ok;
        ok = 1'b0;
        case (c.op)
            OP_SYNC: begin
                // Ticks since the anchor, wrapping at 2^24; the fraction carries over.
                elapsed    = c.count - cal_anchor;
                carry_secs = 32'(elapsed >> FRAC_W);
                cal_frac   = cal_frac + 32'(elapsed[FRAC_W-1:0]);
                carry_secs = carry_secs + (cal_frac >> FRAC_W);
                cal_frac   = cal_frac & 32'h7FFF;
                total      = cal_sec + carry_secs;
                cal_sec    = total % 60;
                total      = cal_min + total / 60;
                cal_min    = total % 60;
                total      = cal_hour + total / 60;
                if (total > 23) begin
                    // Past midnight: one day forward, rolling month and year.
                    cal_hour = total % 24;
                    cal_day  = cal_day + 1;
                    if (cal_day > days_in_month(cal_year, cal_month)) begin
                        cal_day   = 1;
                        cal_month = cal_month + 1;
                        if (cal_month > 12) begin
                            cal_month = 1;
                            cal_year  = (cal_year + 1) & 32'hFFF;
                        end
                    end
                end else begin
                    cal_hour = total;
                end
                cal_anchor = c.count;
                ok = 1'b1;
            end
            OP_SET_TIME: begin
                if (c.hour <= 23 && c.minute <= 59 && c.second <= 59) begin
                    cal_anchor = c.count;
                    cal_hour   = 32'(c.hour);
                    cal_min    = 32'(c.minute);
                    cal_sec    = 32'(c.second);
                    ok = 1'b1;
                end
            end
            OP_SET_DATE: begin
                if (c.year >= DEF_MIN_YEAR && c.year <= DEF_MAX_YEAR &&
                    c.month >= 1 && c.month <= 12 &&
                    c.day >= 1 && c.day <= days_in_month(c.year, c.month)) begin
                    cal_year  = 32'(c.year);
                    cal_month = 32'(c.month);
                    cal_day   = 32'(c.day);
                    ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.accepted = ok;
        r.hour     = HOUR_W'(cal_hour);
        r.minute   = MIN_W'(cal_min);
        r.second   = SEC_W'(cal_sec);
        r.year     = YEAR_W'(cal_year);
        r.month    = MONTH_W'(cal_month);
        r.day      = DAY_W'(cal_day);
        r.weekday  = WDAY_W'(day_of_week(cal_year, cal_month, cal_day));
        return r;
    endfunction

    function automatic rtc_command_t cmd_of(input logic [OP_W-1:0] op,
                                            input logic [COUNT_W-1:0] count,
                                            input int unsigned h, input int unsigned mi,
                                            input int unsigned s, input int unsigned y,
                                            input int unsigned mo, input int unsigned d);
        return '{op, count, FIELD_W'(h), FIELD_W'(mi), FIELD_W'(s), YEAR_W'(y),
                 MONTH_W'(mo), DAY_W'(d)};
    endfunction

    function automatic rtc_reading_t reading_of(input bit acc, input int unsigned h,
                                                input int unsigned mi, input int unsigned s,
                                                input int unsigned y, input int unsigned mo,
                                                input int unsigned d, input int unsigned wd);
        return '{acc, HOUR_W'(h), MIN_W'(mi), SEC_W'(s), YEAR_W'(y), MONTH_W'(mo),
                 DAY_W'(d), WDAY_W'(wd)};
    endfunction

    // Idle cycles before the next item, according to the current sender mode.
    function automatic int unsigned next_gap();
        int unsigned r;
        r = $urandom_range(0, 19);
        case (gap_mode)
            0:       return 0;
            1:       return (r < 5) ? $urandom_range(1, 3) : 0;
            default: return (r == 0) ? $urandom_range(15, 50) : (r < 8) ? $urandom_range(1, 4) : 0;
        endcase
    endfunction

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            note_fault($sformatf("result %0d, %s: expected %0d, got %0d",
                                 results_seen, name, want, got));
        end
    endtask

    // Offers one item, holds it until taken, then records what it should produce.
    task automatic drive_item(input rtc_command_t cmd, input bit pinned,
                              input rtc_reading_t want, input int unsigned gap);
        rtc_reading_t predicted;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= cmd.op;
        s_timer_count <= cmd.count;
        s_hour_in     <= cmd.hour;
        s_minute_in   <= cmd.minute;
        s_second_in   <= cmd.second;
        s_year_in     <= cmd.year;
        s_month_in    <= cmd.month;
        s_day_in      <= cmd.day;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = advance_calendar(cmd);
        expected_readings.push_back(pinned ? want : predicted);
    endtask

    // Result side: compare every item taken with the oldest expectation.
    always @(posedge aclk) begin : result_check
        rtc_reading_t got;
        rtc_reading_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_accepted, m_hour, m_minute, m_second, m_year, m_month, m_day,
                    m_weekday};
            if (expected_readings.size() == 0) begin
                note_fault($sformatf("result %0d arrived with nothing expected",
                                     results_seen));
            end else begin
                want = expected_readings.pop_front();
                check_field("accepted", want.accepted, got.accepted);
                check_field("hour",     want.hour,     got.hour);
                check_field("minute",   want.minute,   got.minute);
                check_field("second",   want.second,   got.second);
                check_field("year",     want.year,     got.year);
                check_field("month",    want.month,    got.month);
                check_field("day",      want.day,      got.day);
                check_field("weekday",  want.weekday,  got.weekday);
            end
            results_seen++;
        end
    end

    // Receiver: runs of ready with short and long stalls, and one long hold-off on request.
    initial begin : ready_driver
        int unsigned run;
        while (!aresetn) @(posedge aclk);
        forever begin
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
            m_ready <= 1'b1;
            repeat (run) @(posedge aclk);
            if (hold_request) begin
                run = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            end
            m_ready <= 1'b0;
            repeat (run) @(posedge aclk);
        end
    end

    // Sender: directed table first, then random items.
    initial begin : stimulus
        rtc_command_t       cmd;
        logic [COUNT_W-1:0] last_reading;
        int unsigned        pick;
        int unsigned        len;

        // After reset, the undefined operation and the extremes of every field.
        directed_rows[0]  = '{cmd_of(OP_UNDEF, 24'hFFFFFF, 255, 255, 255, 4095, 15, 31), 1'b1,
                              reading_of(0, 9, 0, 0, 2010, 1, 1, 4)};
        // Equal reading: nothing elapses.
        directed_rows[1]  = '{cmd_of(OP_SYNC, 24'h000000, 0, 0, 0, 0, 0, 0), 1'b1,
                              reading_of(1, 9, 0, 0, 2010, 1, 1, 4)};
        // Largest span: 511 seconds and a fraction one tick short of a second.
        directed_rows[2]  = '{cmd_of(OP_SYNC, 24'hFFFFFF, 0, 0, 0, 0, 0, 0), 1'b1,
                              reading_of(1, 9, 8, 31, 2010, 1, 1, 4)};
        // One tick across the counter wrap completes the fraction into a second.
        directed_rows[3]  = '{cmd_of(OP_SYNC, 24'h000000, 0, 0, 0, 0, 0, 0), 1'b1,
                              reading_of(1, 9, 8, 32, 2010, 1, 1, 4)};
        directed_rows[4]  = '{cmd_of(OP_SET_TIME, 24'h123456, 23, 59, 59, 0, 0, 0), 1'b1,
                              reading_of(1, 23, 59, 59, 2010, 1, 1, 4)};
        // Rejected set-time items leave the time and the anchor alone.
        directed_rows[5]  = '{cmd_of(OP_SET_TIME, 24'hABCDEF, 24, 0, 0, 0, 0, 0), 1'b1,
                              reading_of(0, 23, 59, 59, 2010, 1, 1, 4)};
        directed_rows[6]  = '{cmd_of(OP_SET_TIME, 24'hABCDEF, 0, 60, 0, 0, 0, 0), 1'b1,
                              reading_of(0, 23, 59, 59, 2010, 1, 1, 4)};
        directed_rows[7]  = '{cmd_of(OP_SET_TIME, 24'hABCDEF, 0, 0, 60, 0, 0, 0), 1'b1,
                              reading_of(0, 23, 59, 59, 2010, 1, 1, 4)};
        directed_rows[8]  = '{cmd_of(OP_SET_TIME, 24'hABCDEF, 255, 255, 255, 0, 0, 0), 1'b1,
                              reading_of(0, 23, 59, 59, 2010, 1, 1, 4)};
        // One second past 23:59:59 wraps the hour and moves to the next day.
        directed_rows[9]  = '{cmd_of(OP_SYNC, 24'h12B456, 0, 0, 0, 0, 0, 0), 1'b1,
                              reading_of(1, 0, 0, 0, 2010, 1, 2, 5)};
        directed_rows[10] = '{cmd_of(OP_SET_DATE, 24'h000000, 0, 0, 0, 2000, 2, 29), 1'b1,
                              reading_of(1, 0, 0, 0, 2000, 2, 29, 1)};
        // Rejected set-date items: year out of range, February of a common year, bad month
        // or day.
        directed_rows[11] = '{cmd_of(OP_SET_DATE, 24'h000000, 0, 0, 0, 2100, 1, 1), 1'b1,
                              reading_of(0, 0, 0, 0, 2000, 2, 29, 1)};
        directed_rows[12] = '{cmd_of(OP_SET_DATE, 24'h000000, 0, 0, 0, 1999, 12, 31), 1'b1,
                              reading_of(0, 0, 0, 0, 2000, 2, 29, 1)};
        directed_rows[13] = '{cmd_of(OP_SET_DATE, 24'h000000, 0, 0, 0, 2001, 2, 29), 1'b1,
                              reading_of(0, 0, 0, 0, 2000, 2, 29, 1)};
        directed_rows[14] = '{cmd_of(OP_SET_DATE, 24'h000000, 0, 0, 0, 2000, 0, 1), 1'b1,
                              reading_of(0, 0, 0, 0, 2000, 2, 29, 1)};
        directed_rows[15] = '{cmd_of(OP_SET_DATE, 24'h000000, 0, 0, 0, 2000, 13, 1), 1'b1,
                              reading_of(0, 0, 0, 0, 2000, 2, 29, 1)};
        directed_rows[16] = '{cmd_of(OP_SET_DATE, 24'h000000, 0, 0, 0, 2000, 1, 0), 1'b1,
                              reading_of(0, 0, 0, 0, 2000, 2, 29, 1)};
        directed_rows[17] = '{cmd_of(OP_SET_DATE, 24'h000000, 0, 0, 0, 2000, 4, 31), 1'b1,
                              reading_of(0, 0, 0, 0, 2000, 2, 29, 1)};
        // Last day of the last valid year, then a carry into the next year.
        directed_rows[18] = '{cmd_of(OP_SET_DATE, 24'h000000, 0, 0, 0, 2099, 12, 31), 1'b0, '0};
        directed_rows[19] = '{cmd_of(OP_SET_TIME, 24'h000000, 23, 59, 59, 0, 0, 0), 1'b0, '0};
        directed_rows[20] = '{cmd_of(OP_SYNC, 24'h010000, 0, 0, 0, 0, 0, 0), 1'b0, '0};
        // Leap day reached by carry, across a counter wrap.
        directed_rows[21] = '{cmd_of(OP_SET_DATE, 24'h000000, 0, 0, 0, 2004, 2, 28), 1'b0, '0};
        directed_rows[22] = '{cmd_of(OP_SET_TIME, 24'hFFF000, 23, 59, 50, 0, 0, 0), 1'b0, '0};
        directed_rows[23] = '{cmd_of(OP_SYNC, 24'h04F000, 0, 0, 0, 0, 0, 0), 1'b0, '0};
        directed_rows[24] = '{cmd_of(OP_SET_TIME, 24'h000000, 0, 0, 0, 0, 0, 0), 1'b0, '0};

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            drive_item(directed_rows[i].cmd, directed_rows[i].pinned, directed_rows[i].want,
                       next_gap());
        end

        last_reading = '0;
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i % 64 == 0) begin
                gap_mode = $urandom_range(0, 2);
            end
            // Ask the receiver for a long hold-off while items keep coming.
            if (i == 300) begin
                hold_request = 1'b1;
            end
            // Let the block drain completely before going on.
            if (i == 900) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (expected_readings.size() != 0);
            end

            // Every field starts fully random; the chosen operation then shapes some of them.
            cmd = '{OP_W'($urandom), COUNT_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
                    FIELD_W'($urandom), YEAR_W'($urandom), MONTH_W'($urandom),
                    DAY_W'($urandom)};
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                // Sync: mostly short spans, some full-range readings, some equal readings.
                cmd.op = OP_SYNC;
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    cmd.count = last_reading;
                end else if (pick >= 4) begin
                    cmd.count = last_reading + COUNT_W'($urandom_range(0, 40) * TICKS_PER_S)
                                + COUNT_W'($urandom_range(0, TICKS_PER_S - 1));
                end
                last_reading = cmd.count;
            end else if (pick < 72) begin
                // Set time: mostly valid and close to midnight, the rest noise.
                cmd.op = OP_SET_TIME;
                if ($urandom_range(0, 3) != 0) begin
                    cmd.hour   = FIELD_W'($urandom_range(0, 1) ? 23 : $urandom_range(0, 23));
                    cmd.minute = FIELD_W'($urandom_range(0, 1) ? $urandom_range(55, 59)
                                                               : $urandom_range(0, 59));
                    cmd.second = FIELD_W'($urandom_range(0, 59));
                    last_reading = cmd.count;
                end
            end else if (pick < 94) begin
                // Set date: mostly valid and often on the last day of a month.
                cmd.op = OP_SET_DATE;
                if ($urandom_range(0, 3) != 0) begin
                    pick = $urandom_range(0, 7);
                    cmd.year  = YEAR_W'((pick == 0) ? DEF_MIN_YEAR :
                                        (pick == 1) ? DEF_MAX_YEAR :
                                        $urandom_range(DEF_MIN_YEAR, DEF_MAX_YEAR));
                    cmd.month = MONTH_W'($urandom_range(1, 12));
                    len = days_in_month(cmd.year, cmd.month);
                    cmd.day = DAY_W'($urandom_range(0, 1) ? len : $urandom_range(1, len));
                    if ($urandom_range(0, 7) == 0) begin
                        cmd.day = DAY_W'(len + 1);
                    end
                end
            end else begin
                cmd.op = OP_UNDEF;
            end
            drive_item(cmd, 1'b0, '0, next_gap());
        end
        s_valid <= 1'b0;

        // Wait for every outstanding result, then a little longer for strays.
        while (expected_readings.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fault_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/rtc_pkg.sv
design/rtc_time_unit.sv
design/rtc_date_unit.sv
design/rtc_calendar_from_tick_counter_unit.sv
dv/rtc_calendar_from_tick_counter_unit_test.sv
